// ===== src/utf8_to_codepoint_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shorthand for the concurrent checks kept at the end of the top level.
// The using scope must provide clk and rst.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U2CP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U2CP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/u2cp_pkg.sv =====
// ---------------------------------------------------------------------------
// u2cp_pkg
// Types, constants and the lead byte classifier of the UTF-8 decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2cp_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int PV_W   = 15;   // gathered bits before the final continuation byte

  // Code point emitted for malformed input.
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Byte class masks and codes.
  localparam logic [BYTE_W-1:0] ASCII_MASK   = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] CONT_CODE    = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] LEAD2_CODE   = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] LEAD3_CODE   = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] LEAD4_MASK   = 8'b1111_1000;
  localparam logic [BYTE_W-1:0] LEAD4_CODE   = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'b0011_1111;

  // Job queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_LW    = 3;

  // One queued job: n_pre replacement results, then value.
  typedef struct packed {
    logic [1:0]      n_pre;
    logic [CP_W-1:0] value;
    logic            eos;
  } u2cp_job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } u2cp_qstat_t;

  // Outcome of reading a byte as the start of a sequence.
  typedef struct packed {
    logic [1:0]      need;
    logic [PV_W-1:0] pv;
    logic            emit;
    logic [CP_W-1:0] value;
  } u2cp_lead_t;

  // Classify a byte as a lead: ASCII, 2/3/4-byte lead or invalid.
  function automatic u2cp_lead_t lead_decode(input logic [BYTE_W-1:0] b);
    u2cp_lead_t r;
    r = '0;
    if ((b & ASCII_MASK) == '0) begin
      r.emit  = 1'b1;
      r.value = {{(CP_W-BYTE_W){1'b0}}, b};
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      r.need = 2'd1;
      r.pv   = {{(PV_W-5){1'b0}}, b[4:0]};
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      r.need = 2'd2;
      r.pv   = {{(PV_W-4){1'b0}}, b[3:0]};
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      r.need = 2'd3;
      r.pv   = {{(PV_W-3){1'b0}}, b[2:0]};
    end else begin
      r.emit  = 1'b1;
      r.value = REPLACEMENT_CP;
    end
    return r;
  endfunction

endpackage

// ===== src/u2cp_ifs.sv =====
// ---------------------------------------------------------------------------
// u2cp interfaces
// Valid/ready channels for incoming bytes and outgoing code points.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Byte channel: one raw byte with its end-of-string mark per item.
interface u2cp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

// Code point channel: one decoded code point with its run and string marks.
interface u2cp_point_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_of_run;
  logic        last_of_string;

  modport source (output valid, output code_point, output last_of_run,
                  output last_of_string, input ready);
  modport sink   (input valid, input code_point, input last_of_run,
                  input last_of_string, output ready);
endinterface

// ===== src/u2cp_front.sv =====
// ---------------------------------------------------------------------------
// u2cp_front
// Accepts bytes, tracks the pending sequence and turns each byte into at
// most one job for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2cp_front (
  input  logic                clk,
  input  logic                rst,
  u2cp_byte_if.sink           text,
  input  logic                q_full,
  output logic                push,
  output u2cp_pkg::u2cp_job_t job,
  output logic                pending
);

  logic [1:0]                  needed;
  logic [1:0]                  needed_next;
  logic [1:0]                  taken;
  logic [1:0]                  taken_next;
  logic [u2cp_pkg::PV_W-1:0]   pv;
  logic [u2cp_pkg::PV_W-1:0]   pv_next;
  u2cp_pkg::u2cp_lead_t        lead;
  logic                        is_cont;
  logic                        lead_emits;
  logic                        emit;
  logic                        fire;

  // A byte is taken whenever the queue has room for its job.
  assign text.ready = !q_full;
  assign fire       = text.valid && text.ready;
  assign push       = fire && emit;
  assign pending    = (needed != 2'd0);

  // Decode the byte against the pending sequence.
  always_comb begin
    lead        = u2cp_pkg::lead_decode(text.byte_in);
    is_cont     = ((text.byte_in & u2cp_pkg::CONT_MASK) == u2cp_pkg::CONT_CODE);
    lead_emits  = lead.emit || ((lead.need != 2'd0) && text.end_of_string);
    emit        = 1'b0;
    job.n_pre   = 2'd0;
    job.value   = u2cp_pkg::REPLACEMENT_CP;
    job.eos     = text.end_of_string;
    needed_next = needed;
    taken_next  = taken;
    pv_next     = pv;
    if (pending && is_cont) begin
      if (needed == 2'd1) begin
        // Final continuation byte completes the code point.
        emit        = 1'b1;
        job.value   = {pv, text.byte_in[5:0]};
        needed_next = 2'd0;
        taken_next  = 2'd0;
        pv_next     = '0;
      end else begin
        needed_next = needed - 2'd1;
        taken_next  = taken + 2'd1;
        pv_next     = {pv[u2cp_pkg::PV_W-7:0], text.byte_in[5:0]};
        // Cut off at the end of the string: lead plus every continuation.
        if (text.end_of_string) begin
          emit      = 1'b1;
          job.n_pre = taken + 2'd1;
        end
      end
    end else begin
      // Any pending sequence is broken; this byte starts afresh as a lead.
      if (lead_emits) begin
        emit      = 1'b1;
        job.n_pre = pending ? (taken + 2'd1) : 2'd0;
        job.value = lead.emit ? lead.value : u2cp_pkg::REPLACEMENT_CP;
      end else if (pending) begin
        emit      = 1'b1;
        job.n_pre = taken;
      end
      needed_next = lead.need;
      taken_next  = 2'd0;
      pv_next     = lead.pv;
    end
    // The decoder is idle after the last byte of a string.
    if (text.end_of_string) begin
      needed_next = 2'd0;
      taken_next  = 2'd0;
      pv_next     = '0;
    end
  end

  // Sequence state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      needed <= 2'd0;
      taken  <= 2'd0;
    end else if (fire) begin
      needed <= needed_next;
      taken  <= taken_next;
    end
  end

  // Gathered bits are only read while a sequence is pending.
  always_ff @(posedge clk) begin
    if (fire) begin
      pv <= pv_next;
    end
  end

endmodule

// ===== src/u2cp_queue.sv =====
// ---------------------------------------------------------------------------
// u2cp_queue
// Short job queue between the byte front and the result back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2cp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  u2cp_pkg::u2cp_job_t   push_job,
  input  logic                  pop,
  output u2cp_pkg::u2cp_job_t   head,
  output u2cp_pkg::u2cp_qstat_t status
);

  u2cp_pkg::u2cp_job_t             slots [u2cp_pkg::QUEUE_DEPTH];
  logic [u2cp_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [u2cp_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [u2cp_pkg::QUEUE_LW-1:0]   level;
  logic [u2cp_pkg::QUEUE_LW-1:0]   level_next;

  // Status and head item.
  assign status.full  = (level == u2cp_pkg::QUEUE_LW'(u2cp_pkg::QUEUE_DEPTH));
  assign status.empty = (level == '0);
  assign head         = slots[rd_ptr];

  always_comb begin
    level_next = level + {{(u2cp_pkg::QUEUE_LW-1){1'b0}}, push}
                       - {{(u2cp_pkg::QUEUE_LW-1){1'b0}}, pop};
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + u2cp_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + u2cp_pkg::QUEUE_AW'(1);
      end
      level <= level_next;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/u2cp_back.sv =====
// ---------------------------------------------------------------------------
// u2cp_back
// Expands the job at the queue head into its run of code point items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2cp_back (
  input  logic                clk,
  input  logic                rst,
  input  u2cp_pkg::u2cp_job_t head,
  input  logic                empty,
  output logic                pop,
  u2cp_point_if.source        points
);

  logic [1:0] idx;
  logic       last;
  logic       fire;

  // Replacement items come first, the job's value last.
  assign last                  = (idx == head.n_pre);
  assign points.valid          = !empty;
  assign points.code_point     = last ? head.value : u2cp_pkg::REPLACEMENT_CP;
  assign points.last_of_run    = last;
  assign points.last_of_string = last && head.eos;
  assign fire                  = points.valid && points.ready;
  assign pop                   = fire && last;

  // Position within the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= last ? 2'd0 : (idx + 2'd1);
    end
  end

endmodule

// ===== src/utf8_to_codepoint_decoder.sv =====
// ---------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Decodes a UTF-8 byte stream into code points, one byte per cycle. Each
// byte is classified combinationally and yields zero to four items: the
// decoded code point, or U+FFFD for every byte of a malformed or truncated
// sequence, with the offending byte then decoded again as a lead. A byte's
// job is registered in the queue before its first item is offered. The byte
// side sustains one byte per cycle while the result side keeps up; a byte
// that yields more than one item holds the result side until all are taken,
// and the four-job queue between the two sides absorbs such bursts before
// the byte side stalls. last_of_run marks the final item of each byte and
// last_of_string that of the string. No overlong or surrogate checks are made.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_to_codepoint_decoder_assert.svh"

module utf8_to_codepoint_decoder (
  input  logic         clk,
  input  logic         rst,
  u2cp_byte_if.sink    text,
  u2cp_point_if.source points
);

  u2cp_pkg::u2cp_job_t   job;
  u2cp_pkg::u2cp_job_t   head;
  u2cp_pkg::u2cp_qstat_t qstat;
  logic                  push;
  logic                  pop;
  logic                  front_pending;

  // Byte classification and sequence tracking.
  u2cp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .q_full  (qstat.full),
    .push    (push),
    .job     (job),
    .pending (front_pending)
  );

  // Job queue between the two sides.
  u2cp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .status   (qstat)
  );

  // Result expansion.
  u2cp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (qstat.empty),
    .pop    (pop),
    .points (points)
  );

  // The last byte of a string leaves no sequence pending.
  `U2CP_ASSERT_NEXT(a_end_clears, text.valid && text.ready && text.end_of_string, !front_pending, "sequence still pending after end of string")

  // A run that is not finished keeps presenting items.
  `U2CP_ASSERT_NEXT(a_run_holds, points.valid && points.ready && !points.last_of_run, points.valid, "run of items broken off")

  // Items are offered only while the queue holds a job.
  `U2CP_ASSERT_SAME(a_empty_quiet, qstat.empty, !points.valid, "item offered from an empty queue")

endmodule

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to code point decoder. Bytes are driven
// on the byte channel while the code point channel is drained under varied
// back-pressure. A scoreboard tracks the decoder state, works out the code
// points each accepted byte should yield and checks every result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 10;
  localparam int DRAIN_LIMIT = 50000;

  // Tracks the decoder state and the queue of code points still owed.
  class cp_scoreboard;
    typedef struct {
      logic [u2cp_pkg::CP_W-1:0] cp;
      logic                      run_end;
      logic                      str_end;
    } cp_item_t;

    cp_item_t                  owed_q[$];
    cp_item_t                  step_q[$];
    int                        errors;
    logic [2:0]                need;
    logic [1:0]                taken;
    logic [u2cp_pkg::CP_W-1:0] partial;

    function new();
      errors  = 0;
      need    = '0;
      taken   = '0;
      partial = '0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_cp(input logic [u2cp_pkg::CP_W-1:0] cp);
      cp_item_t it;
      if (step_q.size() < 4) begin
        it.cp      = cp;
        it.run_end = 1'b0;
        it.str_end = 1'b0;
        step_q.push_back(it);
      end
    endfunction

    // One replacement for the lead and one for each continuation taken.
    function void abandon_sequence();
      for (int k = 0; k <= int'(taken); k++) push_cp(u2cp_pkg::REPLACEMENT_CP);
      need    = '0;
      taken   = '0;
      partial = '0;
    endfunction

    // Read a byte as the start of a new sequence.
    function void take_lead(input logic [7:0] b, input logic eos);
      need    = '0;
      taken   = '0;
      partial = '0;
      if ((b & u2cp_pkg::ASCII_MASK) == '0) begin
        push_cp({13'd0, b});
      end else if ((b & u2cp_pkg::LEAD2_MASK) == u2cp_pkg::LEAD2_CODE) begin
        need    = 3'd1;
        partial = {16'd0, b[4:0]};
      end else if ((b & u2cp_pkg::LEAD3_MASK) == u2cp_pkg::LEAD3_CODE) begin
        need    = 3'd2;
        partial = {17'd0, b[3:0]};
      end else if ((b & u2cp_pkg::LEAD4_MASK) == u2cp_pkg::LEAD4_CODE) begin
        need    = 3'd3;
        partial = {18'd0, b[2:0]};
      end else begin
        push_cp(u2cp_pkg::REPLACEMENT_CP);
      end
      if (eos && need != 0) abandon_sequence();
    endfunction

    // Work out the code points owed for one accepted byte.
    function void note_byte(input logic [7:0] b, input logic eos);
      step_q.delete();
      if (need != 0) begin
        if ((b & u2cp_pkg::CONT_MASK) == u2cp_pkg::CONT_CODE) begin
          partial = {partial[u2cp_pkg::CP_W-7:0], b[5:0]};
          need    = need - 3'd1;
          if (need == 0) begin
            push_cp(partial);
            taken   = '0;
            partial = '0;
          end else begin
            taken = taken + 2'd1;
            if (eos) abandon_sequence();
          end
        end else begin
          abandon_sequence();
          take_lead(b, eos);
        end
      end else begin
        take_lead(b, eos);
      end
      if (step_q.size() > 0) begin
        step_q[step_q.size()-1].run_end = 1'b1;
        step_q[step_q.size()-1].str_end = eos;
      end
      if (eos) begin
        need    = '0;
        taken   = '0;
        partial = '0;
      end
      foreach (step_q[i]) owed_q.push_back(step_q[i]);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    // Compare one delivered code point with the oldest one owed.
    task check_point(input logic [u2cp_pkg::CP_W-1:0] cp, input logic run_end,
                     input logic str_end);
      cp_item_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("code point %h arrived with none owed", cp));
      end else begin
        want = owed_q.pop_front();
        if (cp !== want.cp)
          report($sformatf("code_point %h, wanted %h", cp, want.cp));
        if (run_end !== want.run_end)
          report($sformatf("last_of_run %b, wanted %b on %h", run_end, want.run_end,
                           want.cp));
        if (str_end !== want.str_end)
          report($sformatf("last_of_string %b, wanted %b on %h", str_end,
                           want.str_end, want.cp));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  u2cp_byte_if  byte_ch ();
  u2cp_point_if point_ch ();

  utf8_to_codepoint_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .text   (byte_ch),
    .points (point_ch)
  );

  cp_scoreboard book;
  logic [7:0]   text_buf[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_asked;
  int           hold_seen;
  int           hold_left;

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    point_ch.ready = 1'b0;
    hold_seen      = 0;
    hold_left      = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        point_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_asked) begin
        hold_seen       = hold_asked;
        hold_left       = HOLD_CYCLES;
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every delivered code point is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && point_ch.valid && point_ch.ready)
      book.check_point(point_ch.code_point, point_ch.last_of_run,
                       point_ch.last_of_string);
  end

  // Offer one byte, with random idle cycles first; returns at the next falling
  // edge after the byte has been taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.byte_in       <= b;
    byte_ch.end_of_string <= eos;
    do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    book.note_byte(b, eos);
    @(negedge clk);
  endtask

  // Send the buffered string, marking its final byte.
  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Append a lead for an n-byte sequence and the given number of
  // continuation bytes, all with random payload bits.
  task automatic add_sequence(input int n, input int conts);
    case (n)
      1:       text_buf.push_back({1'b0, 7'($urandom)});
      2:       text_buf.push_back({3'b110, 5'($urandom)});
      3:       text_buf.push_back({4'b1110, 4'($urandom)});
      default: text_buf.push_back({5'b11110, 3'($urandom)});
    endcase
    repeat (conts) text_buf.push_back({2'b10, 6'($urandom)});
  endtask

  // Random strings: mostly well-formed sequences, some stray bytes and
  // some sequences cut short.
  task automatic send_random(input int n_bytes);
    int sent;
    int units;
    int n;
    int r;
    sent = 0;
    while (sent < n_bytes) begin
      units = $urandom_range(1, 6);
      repeat (units) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          n = $urandom_range(1, 4);
          add_sequence(n, n - 1);
        end else if (r < 87) begin
          text_buf.push_back(8'($urandom));
        end else begin
          n = $urandom_range(2, 4);
          add_sequence(n, $urandom_range(0, n - 2));
        end
      end
      sent += text_buf.size();
      send_text();
    end
  endtask

  // Stop offering bytes until every owed code point has arrived.
  task automatic wait_drained();
    int guard;
    guard = 0;
    byte_ch.valid <= 1'b0;
    while (book.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    book                  = new();
    rst                   = 1'b1;
    byte_ch.valid         = 1'b0;
    byte_ch.byte_in       = '0;
    byte_ch.end_of_string = 1'b0;
    hold_asked            = 0;
    send_idle_pct         = 20;
    recv_idle_pct         = 83;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ASCII extremes.
    text_buf = '{8'h00, 8'h7F};
    send_text();
    // Two-, three- and four-byte sequences, the last giving the top code point.
    text_buf = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_text();
    // Stray continuation bytes and invalid leads.
    text_buf = '{8'h80, 8'hBF, 8'hF8, 8'hFF};
    send_text();
    // A sequence broken by an ASCII byte.
    text_buf = '{8'hE2, 8'h82, 8'h41};
    send_text();
    // A broken four-byte sequence whose breaking lead is itself the last byte.
    text_buf = '{8'hF0, 8'h9F, 8'h98, 8'hF5};
    send_text();
    // A sequence cut off by the end of the string.
    text_buf = '{8'hF0, 8'h9F, 8'h98};
    send_text();
    // A lone multi-byte lead as the whole string.
    text_buf = '{8'hC3};
    send_text();

    send_random(170);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 20;
    send_random(170);
    wait_drained();

    // Full rate, opening with a long receiver hold-off so the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    send_random(170);
    wait_drained();

    if (book.outstanding() != 0)
      book.report($sformatf("%0d code points never arrived", book.outstanding()));
    if (book.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("tb: errors");
    $finish;
  end

endmodule
